/* rtl/core/assert_macros.svh */
// assertion macros shared by the scanner rtl
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/core/wss_pkg.sv */
// wss_pkg: types, register indexes and limits of the signature scanner
// no dependencies
`default_nettype none
package wss_pkg;

  localparam int unsigned PatternMax = 32;
  localparam int unsigned OffsetMax  = 28;
  localparam int unsigned WordBytes  = 4;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPattern0 = 4'd0;
  localparam logic [CfgIdxW-1:0] RegPattern1 = 4'd1;
  localparam logic [CfgIdxW-1:0] RegPattern2 = 4'd2;
  localparam logic [CfgIdxW-1:0] RegPattern3 = 4'd3;
  localparam logic [CfgIdxW-1:0] RegMask     = 4'd4;
  localparam logic [CfgIdxW-1:0] RegLength   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegOffset   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegOpcodes  = 4'd7;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [AddrW-1:0] byte_address;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] patch_address;
    logic [31:0]      instruction_word;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // per-cell compare and word select controls
  typedef struct packed {
    logic [7:0]           expected;
    logic                 care;
    logic [WordBytes-1:0] word_sel;
  } cell_ctl_t;

  // scan-wide values derived from the registers
  typedef struct packed {
    logic [5:0]       span;
    logic [AddrW-1:0] addr_delta;
    logic [7:0]       opcode_lo;
    logic [7:0]       opcode_hi;
  } scan_cfg_t;

endpackage
`default_nettype wire

/* rtl/core/wss_chan_if.sv */
// wss_chan_if: valid/ready channel carrying one payload per transaction
// payload type given by parameter, usually from wss_pkg
`default_nettype none
interface wss_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/wss_cell.sv */
// wss_cell: one byte of the sliding window with its pattern compare
// depends on wss_pkg
`default_nettype none
module wss_cell import wss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic [7:0]  byte_i,
  input  cell_ctl_t   ctl_i,
  output logic [7:0]  byte_o,
  output logic        match_o,
  output logic [31:0] word_part_o
);

  logic [7:0] byte_q;

  // window byte, moves one age older per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign match_o = !ctl_i.care || (byte_q == ctl_i.expected);

  // place the byte into its lane of the instruction word
  always_comb begin
    word_part_o = '0;
    for (int b = 0; b < WordBytes; b++) begin
      if (ctl_i.word_sel[b]) begin
        word_part_o[8*b +: 8] = byte_q;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wss_cfg.sv */
// wss_cfg: configuration registers and per-cell control derivation
// depends on wss_pkg
`default_nettype none
module wss_cfg import wss_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  input  cfg_wr_t   wr_i,
  output scan_cfg_t scan_o,
  output cell_ctl_t ctl_o [WINDOW_BYTES]
);

  localparam logic [5:0] LenLimit =
    6'((WINDOW_BYTES < PatternMax) ? WINDOW_BYTES : PatternMax);
  localparam logic [4:0] OffLimit =
    5'((WINDOW_BYTES - 4 < OffsetMax) ? WINDOW_BYTES - 4 : OffsetMax);

  logic [3:0][63:0] pattern_q;
  logic [31:0]      mask_q;
  logic [5:0]       length_q;
  logic [4:0]       offset_q;
  logic [15:0]      opcodes_q;

  logic [5:0] len_eff;
  logic [4:0] off_eff;
  logic [5:0] off_end;
  logic [5:0] span;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      mask_q    <= '0;
      length_q  <= 6'd1;
      offset_q  <= '0;
      opcodes_q <= '0;
    end else if (wr_valid_i) begin
      unique case (wr_i.index)
        RegPattern0: pattern_q[0] <= wr_i.data;
        RegPattern1: pattern_q[1] <= wr_i.data;
        RegPattern2: pattern_q[2] <= wr_i.data;
        RegPattern3: pattern_q[3] <= wr_i.data;
        RegMask:     mask_q       <= wr_i.data[31:0];
        RegLength:   length_q     <= wr_i.data[5:0];
        RegOffset:   offset_q     <= wr_i.data[4:0];
        RegOpcodes:  opcodes_q    <= wr_i.data[15:0];
        default: ;
      endcase
    end
  end

  // clamp length and offset, span covers pattern and word
  always_comb begin
    if (length_q == '0) begin
      len_eff = 6'd1;
    end else if (length_q > LenLimit) begin
      len_eff = LenLimit;
    end else begin
      len_eff = length_q;
    end
    off_eff = (offset_q > OffLimit) ? OffLimit : offset_q;
    off_end = {1'b0, off_eff} + 6'd4;
    span    = (off_end > len_eff) ? off_end : len_eff;
  end

  assign scan_o.span       = span;
  assign scan_o.addr_delta = AddrW'(off_eff) - AddrW'(span) + AddrW'(1);
  assign scan_o.opcode_lo  = opcodes_q[7:0];
  assign scan_o.opcode_hi  = opcodes_q[15:8];

  // cell at age i sees pattern entry span-1-i
  for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_ctl
    localparam logic [6:0] Age = 7'(i);
    logic [6:0] idx;
    logic       in_span;

    always_comb begin
      idx     = {1'b0, span} - 7'd1 - Age;
      in_span = Age < {1'b0, span};
      ctl_o[i].care     = in_span && (idx < {1'b0, len_eff}) && !mask_q[idx[4:0]];
      ctl_o[i].expected = pattern_q[idx[4:3]][{idx[2:0], 3'b000} +: 8];
      for (int b = 0; b < WordBytes; b++) begin
        ctl_o[i].word_sel[b] = in_span && (idx == ({2'b00, off_eff} + 7'(b)));
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wildcard_signature_scanner.sv */
// a taken byte enters the window cells and the evaluation stage; its result then goes to the output register
// throughput: one byte per cycle; the cell chain shifts once per accepted byte
// input stalls only while a result is pending and the output register is held
// reset: asynchronous, clears window cells, byte counter, hit flag and output valid;
// registers return to their defaults (length 1, all others zero)
`default_nettype none
`include "assert_macros.svh"
module wildcard_signature_scanner import wss_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wss_chan_if.sink     cfg_chan_i,
  wss_chan_if.sink     in_chan_i,
  wss_chan_if.source   out_chan_o
);

  localparam int unsigned SeenW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned CmpW  = (SeenW > 6) ? SeenW : 6;
  localparam logic [SeenW-1:0] SeenMax = SeenW'(WINDOW_BYTES);

  scan_cfg_t   scan;
  cell_ctl_t   ctl [WINDOW_BYTES];
  logic [7:0]  win_byte [WINDOW_BYTES];
  logic [31:0] word_part [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] cell_match;

  logic             accept;
  logic             advance;
  logic             stall;
  logic [SeenW-1:0] seen_q, seen_d, seen_inc;
  logic             s1_valid_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_last_q;
  logic [SeenW-1:0] s1_seen_q;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;

  logic        win_match;
  logic [31:0] word;
  logic        span_met;
  logic        is_hit;
  logic        has_result;

  // configuration
  assign cfg_chan_i.ready = 1'b1;

  wss_cfg #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(cfg_chan_i.valid),
    .wr_i      (cfg_chan_i.payload),
    .scan_o    (scan),
    .ctl_o     (ctl)
  );

  // window cell chain, cell 0 holds the newest byte
  for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
    logic [7:0] chain_in;
    if (i == 0) begin : g_head
      assign chain_in = in_chan_i.payload.data_byte;
    end else begin : g_body
      assign chain_in = win_byte[i-1];
    end
    wss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .byte_i     (chain_in),
      .ctl_i      (ctl[i]),
      .byte_o     (win_byte[i]),
      .match_o    (cell_match[i]),
      .word_part_o(word_part[i])
    );
  end

  // combine cell results for the candidate ending at the s1 byte
  always_comb begin
    word = '0;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      word = word | word_part[i];
    end
  end

  assign win_match  = &cell_match;
  assign span_met   = CmpW'(s1_seen_q) >= CmpW'(scan.span);
  assign is_hit     = s1_valid_q && !hit_q && span_met && win_match &&
                      ((word[31:24] == scan.opcode_lo) || (word[31:24] == scan.opcode_hi));
  assign has_result = is_hit || (s1_valid_q && s1_last_q && !hit_q);

  // handshake: hold everything while a result cannot be written out
  assign stall           = has_result && out_valid_q && !out_chan_o.ready;
  assign advance         = !stall;
  assign in_chan_i.ready = advance;
  assign accept          = in_chan_i.valid && advance;

  // stream byte count, saturating
  assign seen_inc = (seen_q == SeenMax) ? seen_q : seen_q + SeenW'(1);
  assign seen_d   = in_chan_i.payload.last_byte ? '0 : seen_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
    end
  end

  // evaluation stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  // evaluation stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= in_chan_i.payload.byte_address;
      s1_last_q <= in_chan_i.payload.last_byte;
      s1_seen_q <= seen_inc;
    end
  end

  // first hit of a stream blocks further results until its end
  always_comb begin
    hit_d = hit_q;
    if (s1_valid_q && advance) begin
      if (is_hit) begin
        hit_d = !s1_last_q;
      end else if (s1_last_q) begin
        hit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // output register
  assign out_valid_d = (out_valid_q && !out_chan_o.ready) || (has_result && advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result && advance) begin
      out_q.found            <= is_hit;
      out_q.patch_address    <= is_hit ? (s1_addr_q + scan.addr_delta) : '0;
      out_q.instruction_word <= is_hit ? word : '0;
    end
  end

  assign out_chan_o.valid   = out_valid_q;
  assign out_chan_o.payload = out_q;

  // checks
  `ASSERT_NEVER(a_seen_bound, seen_q > SeenMax, "byte count above window size")
  `ASSERT_PROP(a_last_rearms, s1_valid_q && s1_last_q && advance |=> !hit_q, "stream end did not rearm")
  `ASSERT_PROP(a_stall_holds, stall |=> s1_valid_q && $stable(s1_addr_q), "stalled stage changed")
  `ASSERT_PROP(a_hit_gated, is_hit |-> span_met && !hit_q, "hit before span complete")

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for wildcard_signature_scanner, byte streams in, scan reports out
// depends on wss_pkg, wss_chan_if and the scanner rtl
module tb import wss_pkg::*; ();

  localparam int unsigned WindowBytes = 32;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned PhaseBytes  = 162;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned CycleLimit  = 600000;

  // predicts scan reports from accepted bytes and checks the ones that come out
  class scan_scoreboard;
    logic [63:0] pattern_regs [4];
    logic [31:0] wild_mask;
    logic [5:0]  pat_len_reg;
    logic [4:0]  offset_reg;
    logic [15:0] opcode_regs;
    logic [7:0]  window [WindowBytes];
    int unsigned bytes_in_stream;
    bit          hit_taken;
    out_item_t   pending_reports [$];
    int unsigned mismatches;

    function new();
      foreach (pattern_regs[i]) pattern_regs[i] = '0;
      foreach (window[i]) window[i] = '0;
      wild_mask       = '0;
      pat_len_reg     = 6'd1;
      offset_reg      = '0;
      opcode_regs     = '0;
      bytes_in_stream = 0;
      hit_taken       = 1'b0;
      mismatches      = 0;
    endfunction

    function void write_reg(cfg_wr_t wr);
      case (wr.index)
        RegPattern0: pattern_regs[0] = wr.data;
        RegPattern1: pattern_regs[1] = wr.data;
        RegPattern2: pattern_regs[2] = wr.data;
        RegPattern3: pattern_regs[3] = wr.data;
        RegMask:     wild_mask = wr.data[31:0];
        RegLength:   pat_len_reg = wr.data[5:0];
        RegOffset:   offset_reg = wr.data[4:0];
        RegOpcodes:  opcode_regs = wr.data[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      int unsigned l;
      l = pat_len_reg;
      if (l == 0) l = 1;
      if (l > PatternMax) l = PatternMax;
      if (l > WindowBytes) l = WindowBytes;
      return l;
    endfunction

    function int unsigned eff_off();
      int unsigned o;
      o = offset_reg;
      if (o > OffsetMax) o = OffsetMax;
      if (o > WindowBytes - WordBytes) o = WindowBytes - WordBytes;
      return o;
    endfunction

    function int unsigned eff_span();
      return (eff_off() + WordBytes > eff_len()) ? eff_off() + WordBytes : eff_len();
    endfunction

    function logic [7:0] pattern_byte(int unsigned j);
      return pattern_regs[j / 8][8 * (j % 8) +: 8];
    endfunction

    // shift one byte in and queue the report it causes, if any
    function void take_byte(in_item_t it);
      int unsigned len, off, span;
      bit match;
      logic [31:0] word;
      logic [AddrW-1:0] start;
      out_item_t rep;
      for (int unsigned i = WindowBytes - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = it.data_byte;
      if (bytes_in_stream < WindowBytes) bytes_in_stream++;
      len  = eff_len();
      off  = eff_off();
      span = eff_span();

      // candidate whose span ends with this byte
      if (!hit_taken && bytes_in_stream >= span) begin
        match = 1'b1;
        for (int unsigned j = 0; j < len; j++)
          if (!wild_mask[j] && pattern_byte(j) != window[span-1-j]) match = 1'b0;
        if (match) begin
          for (int unsigned b = 0; b < WordBytes; b++) word[8*b +: 8] = window[span-1-off-b];
          if (word[31:24] == opcode_regs[7:0] || word[31:24] == opcode_regs[15:8]) begin
            start                = it.byte_address - AddrW'(span - 1);
            rep.found            = 1'b1;
            rep.patch_address    = start + AddrW'(off);
            rep.instruction_word = word;
            pending_reports.push_back(rep);
            hit_taken = !it.last_byte;
            if (it.last_byte) bytes_in_stream = 0;
            return;
          end
        end
      end

      // end of stream: no-hit report unless a hit went out
      if (it.last_byte) begin
        if (!hit_taken) begin
          rep = '0;
          pending_reports.push_back(rep);
        end
        bytes_in_stream = 0;
        hit_taken       = 1'b0;
      end
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= MaxShown)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("report with none expected: found %0b addr %h word %h",
                   got.found, got.patch_address, got.instruction_word);
        return;
      end
      want = pending_reports.pop_front();
      if (got.found !== want.found) flag("found", want.found, got.found);
      if (got.patch_address !== want.patch_address)
        flag("patch_address", want.patch_address, got.patch_address);
      if (got.instruction_word !== want.instruction_word)
        flag("instruction_word", want.instruction_word, got.instruction_word);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  wss_chan_if #(.payload_t(cfg_wr_t))   cfg_chan ();
  wss_chan_if #(.payload_t(in_item_t))  in_chan ();
  wss_chan_if #(.payload_t(out_item_t)) out_chan ();

  scan_scoreboard sb = new();

  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          in_quiet;
  bit          out_quiet;
  logic [7:0]  stream_q [$];

  wildcard_signature_scanner #(.WINDOW_BYTES(WindowBytes)) dut (
    .clk_i,
    .rst_ni,
    .cfg_chan_i (cfg_chan),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // observe every transaction on the three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_chan.valid && out_chan.ready) sb.check_report(out_chan.payload);
      if (cfg_chan.valid && cfg_chan.ready) sb.write_reg(cfg_chan.payload);
      if (in_chan.valid && in_chan.ready) sb.take_byte(in_chan.payload);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // report sink with random back-pressure
  initial begin
    int unsigned g;
    out_chan.ready = 1'b0;
    out_quiet      = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
      g = (out_quiet || $urandom_range(0, 3) != 0) ? 0 : idle_gap();
      if (g != 0) begin
        out_chan.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  function automatic logic [AddrW-1:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return {AddrW{1'b1}} - AddrW'($urandom_range(0, 40));
    if (r == 1) return AddrW'($urandom_range(0, 8));
    return rand_addr();
  endfunction

  task automatic send_byte(logic [7:0] b, logic [AddrW-1:0] a, logic last);
    in_item_t it;
    int unsigned g;
    it.data_byte    = b;
    it.byte_address = a;
    it.last_byte    = last;
    in_chan.valid   <= 1'b1;
    in_chan.payload <= it;
    do @(posedge clk_i); while (!in_chan.ready);
    bytes_sent++;
    g = in_quiet ? 0 : idle_gap();
    if (g != 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // send stream_q as one stream, last byte flagged
  task automatic send_stream(logic [AddrW-1:0] base, bit scatter);
    for (int unsigned i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], scatter ? rand_addr() : base + AddrW'(i),
                i == stream_q.size() - 1);
  endtask

  function automatic void push_noise(int unsigned n);
    repeat (n) stream_q.push_back(8'($urandom));
  endfunction

  // one candidate span built from the current pattern, optionally corrupted
  function automatic void push_signature(bit broken);
    int unsigned len, off, span, p;
    logic [7:0] body [WindowBytes];
    len  = sb.eff_len();
    off  = sb.eff_off();
    span = sb.eff_span();
    for (int unsigned i = 0; i < span; i++) body[i] = 8'($urandom);
    for (int unsigned j = 0; j < len; j++)
      if (!sb.wild_mask[j]) body[j] = sb.pattern_byte(j);
    p = off + WordBytes - 1;
    if ((p >= len || sb.wild_mask[p]) && $urandom_range(0, 3) != 0)
      body[p] = $urandom_range(0, 1) ? sb.opcode_regs[7:0] : sb.opcode_regs[15:8];
    if (broken) begin
      p = $urandom_range(0, span - 1);
      body[p] = body[p] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (int unsigned i = 0; i < span; i++) stream_q.push_back(body[i]);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_wr_t wr;
    wr.index         = idx;
    wr.data          = data;
    cfg_chan.valid   <= 1'b1;
    cfg_chan.payload <= wr;
    do @(posedge clk_i); while (!cfg_chan.ready);
  endtask

  // stop sending and let every pending report come out
  task automatic settle();
    in_chan.valid <= 1'b0;
    // wait so the monitor has noted the last accepted byte
    @(posedge clk_i);
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // one register setting per phase, extremes in the first phases
  task automatic program_scan(int unsigned phase);
    logic [63:0] pat [4];
    logic [31:0] msk;
    logic [63:0] junk;
    logic [5:0]  len_raw;
    logic [4:0]  off_raw;
    logic [7:0]  op_lo, op_hi;
    int unsigned len_eff, off_eff, p;
    foreach (pat[i]) pat[i] = {$urandom, $urandom};
    case (phase)
      0: begin len_eff = 1;  len_raw = 6'd1;  off_eff = 0;  off_raw = 5'd0;  end
      1: begin len_eff = 32; len_raw = 6'd32; off_eff = 28; off_raw = 5'd28; end
      2: begin len_eff = 1;  len_raw = 6'd0;  off_eff = 28; off_raw = 5'd31; end
      3: begin
        len_eff = 32;
        len_raw = 6'h3f;
        off_eff = 28;
        off_raw = 5'($urandom_range(29, 31));
      end
      default: begin
        len_eff = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
        off_eff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 28) : $urandom_range(0, 6);
        len_raw = 6'(len_eff);
        off_raw = 5'(off_eff);
      end
    endcase
    if (phase == 0) msk = '0;
    else if (phase == 4) msk = '1;
    else msk = $urandom & $urandom;
    op_lo = 8'($urandom);
    op_hi = (phase % 2 == 0) ? op_lo : 8'($urandom);
    if (phase == 5) begin
      op_lo = 8'h00;
      op_hi = 8'hff;
    end
    // make hits reachable when the opcode byte lies under a fixed pattern entry
    p = off_eff + WordBytes - 1;
    if (p < len_eff && !msk[p] && $urandom_range(0, 1)) op_hi = pat[p / 8][8 * (p % 8) +: 8];
    junk = (phase % 2 == 1) ? {$urandom, $urandom} : '0;
    write_reg(RegPattern0, pat[0]);
    write_reg(RegPattern1, pat[1]);
    write_reg(RegPattern2, pat[2]);
    write_reg(RegPattern3, pat[3]);
    write_reg(RegMask, {junk[63:32], msk});
    write_reg(RegLength, {junk[63:6], len_raw});
    write_reg(RegOffset, {junk[63:5], off_raw});
    write_reg(RegOpcodes, {junk[63:16], op_hi, op_lo});
    // index past the register list must be ignored
    if (phase == 2) write_reg(CfgIdxW'(RegOpcodes + 1 + $urandom_range(0, 7)), '1);
    cfg_chan.valid <= 1'b0;
  endtask

  // directed streams under the reset setting: length 1, pattern zero, offset zero
  task automatic directed_streams();
    in_quiet = 1'b0;
    // single byte stream, too short for any candidate
    stream_q = '{8'hff};
    send_stream(48'h0, 1'b0);
    // hit on the last byte, start address wraps below zero
    stream_q = '{8'h00, 8'h11, 8'h22, 8'h00};
    send_stream(48'hffff_ffff_fffe, 1'b0);
    // hit mid stream, later bytes and the last byte stay silent
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a, 8'h00};
    send_stream(48'h7fff_ffff_fffd, 1'b0);
    // no match anywhere, no-hit at the end
    stream_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_stream(48'h8000_0000_0000, 1'b0);
  endtask

  // main sequence
  initial begin
    int unsigned target, kind;
    bit drain_point;
    rst_ni           = 1'b0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.payload = '0;
    in_chan.valid    = 1'b0;
    in_chan.payload  = '0;
    bytes_sent       = 0;
    in_quiet         = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_streams();

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      settle();
      program_scan(phase);
      target      = bytes_sent + PhaseBytes;
      drain_point = (phase == 3 || phase == 7);
      while (bytes_sent < target) begin
        in_quiet = ($urandom_range(0, 9) == 0);
        stream_q.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5 || kind == 9) begin
          push_noise(($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4));
          push_signature($urandom_range(0, 4) == 0);
          if ($urandom_range(0, 4) == 0) push_signature(1'b0);
          push_noise($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
        end else if (kind <= 7) begin
          push_noise($urandom_range(1, 40));
        end else begin
          push_noise($urandom_range(1, sb.eff_span()));
        end
        send_stream(pick_base(), kind == 9);
        // sender holds off until every report is out
        if (drain_point && bytes_sent + 80 >= target) begin
          settle();
          drain_point = 1'b0;
        end
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/wss_pkg.sv
rtl/core/wss_chan_if.sv
rtl/core/wss_cell.sv
rtl/core/wss_cfg.sv
rtl/core/wildcard_signature_scanner.sv
verif/tb.sv
